// ===== design/vtmc_pkg.sv =====
// ----------------------------------------------------------------------------
// vtmc_pkg
// Shared codes, widths and defaults of the voxel template match counter.
// ----------------------------------------------------------------------------
package vtmc_pkg;

    // Default store sizes in voxels
    localparam int VOLUME_VOXELS_DEF   = 65536;
    localparam int TEMPLATE_VOXELS_DEF = 4096;

    // Field widths
    localparam int CMD_W    = 2;
    localparam int ADDR_W   = 16;
    localparam int VOXEL_W  = 32;
    localparam int OFFSET_W = 10;
    localparam int VDIM_W   = 11;
    localparam int TDIM_W   = 7;
    localparam int COUNT_W  = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    // Item commands
    localparam logic [CMD_W-1:0] CMD_LOAD_VOLUME   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_TEMPLATE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY         = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_LENGTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMPLATE_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMPLATE_HEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMPLATE_LENGTH = 3'd5;

    // Match count saturates here
    localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd8191;

endpackage

// ===== design/voxel_template_match_counter_unit.sv =====
// ----------------------------------------------------------------------------
// voxel_template_match_counter_unit
// Holds a voxel volume and a smaller voxel pattern and counts exact matches
// of the pattern placed at a queried offset.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one item per handshake. A load item (volume or
//   pattern) writes one voxel; loads beyond a store are dropped. A query
//   item returns one result item on m_*; other items return nothing.
//   Command code 3 is dropped.
//   Configuration: cfg_we/cfg_index/cfg_wdata write the six size registers
//   (all reset to 1); write them only while no query is in flight.
//   Query sequence: three setup states (S_DIM, S_SIZE, S_BASE) form the
//   size products, fit test and base address. If the pattern fits and is
//   not empty, the walker then reads one volume and one pattern voxel per
//   cycle for all N = template_width * template_height * template_length
//   positions and S_DRAIN finishes the last compare; otherwise the walk is
//   skipped. S_DONE loads the output register.
//   s_ready is low while a query runs and comes back with the result; a
//   new item is taken only once the query is through.
//   If the receiver stalls, the finished result waits in the output
//   register; loads are still taken meanwhile, and a following query runs
//   and holds in its last step until the output register is free.
//   Reset (aresetn low, synchronous) clears the sequencer and the output
//   valid; store contents are undefined until written.
// ----------------------------------------------------------------------------
module voxel_template_match_counter_unit import vtmc_pkg::*; #(
    parameter int VOLUME_VOXELS   = VOLUME_VOXELS_DEF,
    parameter int TEMPLATE_VOXELS = TEMPLATE_VOXELS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_wdata,
    // input items
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [CMD_W-1:0]            s_command,
    input  logic [ADDR_W-1:0]           s_voxel_address,
    input  logic signed [VOXEL_W-1:0]   s_voxel_value,
    input  logic [OFFSET_W-1:0]         s_offset_x,
    input  logic [OFFSET_W-1:0]         s_offset_y,
    input  logic [OFFSET_W-1:0]         s_offset_z,
    // result items
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [COUNT_W-1:0]          m_match_count,
    output logic                        m_in_range
);

    localparam int VA = (VOLUME_VOXELS > 1) ? $clog2(VOLUME_VOXELS) : 1;
    localparam int TA = (TEMPLATE_VOXELS > 1) ? $clog2(TEMPLATE_VOXELS) : 1;

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIM   = 3'd1;
    localparam logic [2:0] S_SIZE  = 3'd2;
    localparam logic [2:0] S_BASE  = 3'd3;
    localparam logic [2:0] S_RUN   = 3'd4;
    localparam logic [2:0] S_DRAIN = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]          state_reg, state_next;

    logic [VDIM_W-1:0]   vw_reg, vh_reg, vl_reg;
    logic [TDIM_W-1:0]   tw_reg, th_reg, tl_reg;

    logic [OFFSET_W-1:0] ox_reg, oy_reg, oz_reg;
    logic [21:0]         area_reg;
    logic [13:0]         tarea_reg;
    logic [20:0]         oyw_reg;
    logic [32:0]         vol_total_reg;
    logic [20:0]         tmpl_total_reg;
    logic [31:0]         ozp_reg;
    logic                fits_reg;

    logic [TDIM_W-1:0]   px_reg, py_reg, pz_reg;
    logic [TA-1:0]       ti_reg;
    logic [VA-1:0]       vi_reg, row_reg, plane_reg;
    logic                rd_pend_reg;
    logic [COUNT_W-1:0]  count_reg;

    logic                m_valid_reg;
    logic [COUNT_W-1:0]  m_count_reg;
    logic                m_in_range_reg;

    logic                s_fire;
    logic                query_fire;
    logic                fits;
    logic                t_empty;
    logic [32:0]         base_sum;
    logic                px_last, py_last, pz_last;
    logic                out_free;
    logic                vol_we, tmp_we;
    logic [VOXEL_W-1:0]  vol_rdata, tmp_rdata;
    logic [VA-1:0]       vw_step, area_step, next_plane;

    assign s_ready    = (state_reg == S_IDLE);
    assign s_fire     = s_valid && s_ready;
    assign query_fire = s_fire && (s_command == CMD_QUERY);
    assign out_free   = !m_valid_reg || m_ready;

    // Store writes from load items
    assign vol_we = s_fire && (s_command == CMD_LOAD_VOLUME) &&
                    (32'(s_voxel_address) < 32'(VOLUME_VOXELS));
    assign tmp_we = s_fire && (s_command == CMD_LOAD_TEMPLATE) &&
                    (32'(s_voxel_address) < 32'(TEMPLATE_VOXELS));

    vtmc_ram #(.WIDTH(VOXEL_W), .DEPTH(VOLUME_VOXELS)) u_volume_ram (
        .aclk  (aclk),
        .we    (vol_we),
        .waddr (VA'(s_voxel_address)),
        .wdata (s_voxel_value),
        .raddr (vi_reg),
        .rdata (vol_rdata)
    );

    vtmc_ram #(.WIDTH(VOXEL_W), .DEPTH(TEMPLATE_VOXELS)) u_template_ram (
        .aclk  (aclk),
        .we    (tmp_we),
        .waddr (TA'(s_voxel_address)),
        .wdata (s_voxel_value),
        .raddr (ti_reg),
        .rdata (tmp_rdata)
    );

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vw_reg <= 11'd1;
            vh_reg <= 11'd1;
            vl_reg <= 11'd1;
            tw_reg <= 7'd1;
            th_reg <= 7'd1;
            tl_reg <= 7'd1;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_VOLUME_WIDTH:    vw_reg <= cfg_wdata;
                CFG_VOLUME_HEIGHT:   vh_reg <= cfg_wdata;
                CFG_VOLUME_LENGTH:   vl_reg <= cfg_wdata;
                CFG_TEMPLATE_WIDTH:  tw_reg <= cfg_wdata[TDIM_W-1:0];
                CFG_TEMPLATE_HEIGHT: th_reg <= cfg_wdata[TDIM_W-1:0];
                CFG_TEMPLATE_LENGTH: tl_reg <= cfg_wdata[TDIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Fit test and base address, evaluated in S_BASE
    assign fits = (vol_total_reg <= 33'(VOLUME_VOXELS)) &&
                  (tmpl_total_reg <= 21'(TEMPLATE_VOXELS)) &&
                  (({1'b0, ox_reg} + {4'd0, tw_reg}) <= vw_reg) &&
                  (({1'b0, oy_reg} + {4'd0, th_reg}) <= vh_reg) &&
                  (({1'b0, oz_reg} + {4'd0, tl_reg}) <= vl_reg);
    assign t_empty  = (tw_reg == '0) || (th_reg == '0) || (tl_reg == '0);
    assign base_sum = {23'd0, ox_reg} + {12'd0, oyw_reg} + {1'b0, ozp_reg};

    // Walker wrap flags and strides
    assign px_last    = (px_reg == tw_reg - 7'd1);
    assign py_last    = (py_reg == th_reg - 7'd1);
    assign pz_last    = (pz_reg == tl_reg - 7'd1);
    assign vw_step    = VA'(vw_reg);
    assign area_step  = VA'(area_reg);
    assign next_plane = plane_reg + area_step;

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (query_fire) state_next = S_DIM;
            S_DIM:   state_next = S_SIZE;
            S_SIZE:  state_next = S_BASE;
            S_BASE:  state_next = (fits && !t_empty) ? S_RUN : S_DONE;
            S_RUN:   if (px_last && py_last && pz_last) state_next = S_DRAIN;
            S_DRAIN: state_next = S_DONE;
            S_DONE:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            rd_pend_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_pend_reg <= (state_reg == S_RUN);
        end
    end

    // Query setup: offsets, size products, fit flag
    always_ff @(posedge aclk) begin
        if (query_fire) begin
            ox_reg <= s_offset_x;
            oy_reg <= s_offset_y;
            oz_reg <= s_offset_z;
        end
        if (state_reg == S_DIM) begin
            area_reg  <= {11'd0, vw_reg} * {11'd0, vh_reg};
            tarea_reg <= {7'd0, tw_reg} * {7'd0, th_reg};
            oyw_reg   <= {11'd0, oy_reg} * {10'd0, vw_reg};
        end
        if (state_reg == S_SIZE) begin
            vol_total_reg  <= {11'd0, area_reg} * {22'd0, vl_reg};
            tmpl_total_reg <= {7'd0, tarea_reg} * {14'd0, tl_reg};
            ozp_reg        <= {22'd0, oz_reg} * {10'd0, area_reg};
        end
        if (state_reg == S_BASE) begin
            fits_reg <= fits;
        end
    end

    // Address walker: pattern index linear, volume index by row and plane
    always_ff @(posedge aclk) begin
        if (state_reg == S_BASE) begin
            px_reg    <= '0;
            py_reg    <= '0;
            pz_reg    <= '0;
            ti_reg    <= '0;
            vi_reg    <= base_sum[VA-1:0];
            row_reg   <= base_sum[VA-1:0];
            plane_reg <= base_sum[VA-1:0];
        end else if (state_reg == S_RUN) begin
            ti_reg <= ti_reg + TA'(1);
            if (!px_last) begin
                px_reg <= px_reg + 7'd1;
                vi_reg <= vi_reg + VA'(1);
            end else begin
                px_reg <= '0;
                if (!py_last) begin
                    py_reg  <= py_reg + 7'd1;
                    row_reg <= row_reg + vw_step;
                    vi_reg  <= row_reg + vw_step;
                end else begin
                    py_reg    <= '0;
                    pz_reg    <= pz_reg + 7'd1;
                    plane_reg <= next_plane;
                    row_reg   <= next_plane;
                    vi_reg    <= next_plane;
                end
            end
        end
    end

    // Match counter, one compare per cycle
    always_ff @(posedge aclk) begin
        if (query_fire) begin
            count_reg <= '0;
        end else if (rd_pend_reg && (vol_rdata == tmp_rdata) && (count_reg != COUNT_MAX)) begin
            count_reg <= count_reg + 13'd1;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == S_DONE) && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == S_DONE) && out_free) begin
            m_count_reg    <= fits_reg ? count_reg : '0;
            m_in_range_reg <= fits_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_match_count = m_count_reg;
    assign m_in_range    = m_in_range_reg;

endmodule

// ===== design/vtmc_ram.sv =====
// ----------------------------------------------------------------------------
// vtmc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vtmc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/vtmc_checker.sv =====
// ----------------------------------------------------------------------------
// vtmc_checker
// Port-level checks of the voxel template match counter, bound to the top.
// ----------------------------------------------------------------------------
module vtmc_checker import vtmc_pkg::*; (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic [CMD_W-1:0]          s_command,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic [COUNT_W-1:0]        m_match_count,
    input logic                      m_in_range
);

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_match_count) && $stable(m_in_range))
        else $error("result changed while stalled");

    // An overhanging pattern never reports matches
    a_out_of_range_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_in_range |-> m_match_count == '0)
        else $error("nonzero count for out-of-range query");

    // Reset empties the output
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A query item occupies the block
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_command == CMD_QUERY) |=> !s_ready)
        else $error("ready right after a query item");

endmodule

bind voxel_template_match_counter_unit vtmc_checker u_vtmc_checker (.*);
